// ===== hw/rtl/datetime_offset_seconds_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the date and time offset block
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef DATETIME_OFFSET_SECONDS_CORE_MACROS_SVH
`define DATETIME_OFFSET_SECONDS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTOS_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("datetime offset check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTOS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("datetime offset check failed");

`endif

// ===== hw/rtl/dtos_pkg.sv =====
// ----------------------------------------------------------------------------
// Date and time offset package
// Field widths, calendar constants, reciprocal constants and the sequencer
// state type shared by the date and time offset block.
// ----------------------------------------------------------------------------
package dtos_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OFFSET_W = 31;

    // Direction codes carried by the opcode field.
    localparam logic OP_FORWARD  = 1'b0;
    localparam logic OP_BACKWARD = 1'b1;

    // Seconds of one day, and the widths that follow from it.
    localparam int SECS_PER_DAY = 86400;
    localparam int TOD_W        = 17;
    localparam int DIVIDEND_W   = 32;
    localparam int QUOT_W       = 16;

    // Whole days by reciprocal multiplication: the dividend is scaled down by 128
    // first, which leaves a division by 675 that is exact for any 25-bit value.
    localparam int DAY_SCALE_SHIFT = 7;
    localparam int DAY_RECIP       = 50903317;
    localparam int DAY_RECIP_SHIFT = 35;
    localparam int DAY_RECIP_W     = 26;

    localparam int MONTH_JAN = 1;
    localparam int MONTH_FEB = 2;
    localparam int MONTH_APR = 4;
    localparam int MONTH_JUN = 6;
    localparam int MONTH_SEP = 9;
    localparam int MONTH_NOV = 11;
    localparam int MONTH_DEC = 12;
    localparam int YEAR_MAX  = 16383;

    // Year within the 400-year cycle.
    localparam int CYCLE_W     = 9;
    localparam int CYCLE_YEARS = 400;

    // Floor quotients by reciprocal multiplication; exact over the value ranges used.
    localparam int Y400_RECIP = 10486;
    localparam int Y400_SHIFT = 22;
    localparam int Y400_Q_W   = 6;
    localparam int HOUR_RECIP = 37283;
    localparam int HOUR_SHIFT = 27;
    localparam int MIN_RECIP  = 4370;
    localparam int MIN_SHIFT  = 18;
    localparam int HREM_W     = 12;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CLAMP,
        ST_DIV,
        ST_ADJ,
        ST_WALK,
        ST_HOUR,
        ST_HREM,
        ST_MIN,
        ST_DONE
    } dtos_state_t;

    // Leap year from the position in the 400-year cycle.
    function automatic logic is_leap(input logic [CYCLE_W-1:0] c400);
        logic leap;
        leap = (c400[1:0] == 2'b00) && (c400 != 9'd100) && (c400 != 9'd200)
            && (c400 != 9'd300);
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_W'(MONTH_FEB))
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (m == MONTH_W'(MONTH_APR) || m == MONTH_W'(MONTH_JUN)
                 || m == MONTH_W'(MONTH_SEP) || m == MONTH_W'(MONTH_NOV))
        begin
            len = 5'd30;
        end
        else
        begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

// ===== hw/rtl/dtos_if.sv =====
// ----------------------------------------------------------------------------
// Date and time offset channels
// Valid/ready channels for the input moment and for the resulting moment.
// ----------------------------------------------------------------------------
interface dtos_item_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic [dtos_pkg::DAY_W-1:0]       day;
    logic [dtos_pkg::MONTH_W-1:0]     month;
    logic [dtos_pkg::YEAR_W-1:0]      year;
    logic [dtos_pkg::HOUR_W-1:0]      hour;
    logic [dtos_pkg::MINUTE_W-1:0]    minute;
    logic [dtos_pkg::SECOND_W-1:0]    second;
    logic [dtos_pkg::OFFSET_W-1:0]    offset_seconds;

    modport source (output valid, opcode, day, month, year, hour, minute, second,
                    offset_seconds, input ready);
    modport sink   (input valid, opcode, day, month, year, hour, minute, second,
                    offset_seconds, output ready);
endinterface

interface dtos_result_if;
    logic                             valid;
    logic                             ready;
    logic [dtos_pkg::DAY_W-1:0]       res_day;
    logic [dtos_pkg::MONTH_W-1:0]     res_month;
    logic [dtos_pkg::YEAR_W-1:0]      res_year;
    logic [dtos_pkg::HOUR_W-1:0]      res_hour;
    logic [dtos_pkg::MINUTE_W-1:0]    res_minute;
    logic [dtos_pkg::SECOND_W-1:0]    res_second;
    logic                             out_of_range;

    modport source (output valid, res_day, res_month, res_year, res_hour, res_minute,
                    res_second, out_of_range, input ready);
    modport sink   (input valid, res_day, res_month, res_year, res_hour, res_minute,
                    res_second, out_of_range, output ready);
endinterface

// ===== hw/rtl/dtos_div.sv =====
// ----------------------------------------------------------------------------
// Seconds-per-day divider
// Splits a 32-bit count of seconds into whole days and remaining seconds by
// reciprocal multiplication, then a multiply-back subtraction.
// ----------------------------------------------------------------------------
module dtos_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [dtos_pkg::DIVIDEND_W-1:0]     dividend,
    output logic                                done,
    output logic [dtos_pkg::QUOT_W-1:0]         quotient,
    output logic [dtos_pkg::TOD_W-1:0]          remainder
);

    localparam int SCALED_W = dtos_pkg::DIVIDEND_W - dtos_pkg::DAY_SCALE_SHIFT;
    localparam int RPROD_W  = SCALED_W + dtos_pkg::DAY_RECIP_W;

    logic                              mul_step_reg;
    logic                              sub_step_reg;
    logic                              done_reg;
    logic [dtos_pkg::DIVIDEND_W-1:0]   num_reg;
    logic [dtos_pkg::QUOT_W-1:0]       quot_reg;
    logic [dtos_pkg::TOD_W-1:0]        rem_reg;

    logic [RPROD_W-1:0]                recip_prod;
    logic [dtos_pkg::DIVIDEND_W-1:0]   day_prod;

    always_comb
    begin
        recip_prod = RPROD_W'(num_reg[dtos_pkg::DIVIDEND_W-1:dtos_pkg::DAY_SCALE_SHIFT])
                   * RPROD_W'(dtos_pkg::DAY_RECIP);
        day_prod   = dtos_pkg::DIVIDEND_W'(quot_reg)
                   * dtos_pkg::DIVIDEND_W'(dtos_pkg::SECS_PER_DAY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_step_reg <= 1'b0;
            sub_step_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            mul_step_reg <= start;
            sub_step_reg <= mul_step_reg;
            done_reg     <= sub_step_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
        end
        if (mul_step_reg)
        begin
            quot_reg <= recip_prod[dtos_pkg::DAY_RECIP_SHIFT +: dtos_pkg::QUOT_W];
        end
        if (sub_step_reg)
        begin
            rem_reg <= dtos_pkg::TOD_W'(num_reg - day_prod);
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/datetime_offset_seconds_core.sv =====
// ----------------------------------------------------------------------------
// Date and time offset core
// The block works on one transaction at a time: it accepts a new input only once
// the result of the last one is loaded into the output register. The month walk
// crosses each month boundary in turn, up to about 820 of them, and dominates the
// time per transaction; a result that waits for ready holds the block in its last state.
// Reset: rst_n clears the sequencer and the output valid asynchronously.
// ----------------------------------------------------------------------------
module datetime_offset_seconds_core (
    input  logic           clk,
    input  logic           rst_n,
    dtos_item_if.sink      item,
    dtos_result_if.source  result
);

    dtos_pkg::dtos_state_t state_reg, state_next;

    // Raw fields kept for the out-of-range echo.
    logic [dtos_pkg::DAY_W-1:0]      raw_day_reg;
    logic [dtos_pkg::MONTH_W-1:0]    raw_month_reg;
    logic [dtos_pkg::YEAR_W-1:0]     raw_year_reg;
    logic [dtos_pkg::HOUR_W-1:0]     raw_hour_reg;
    logic [dtos_pkg::MINUTE_W-1:0]   raw_minute_reg;
    logic [dtos_pkg::SECOND_W-1:0]   raw_second_reg;

    logic                            op_reg;
    logic [dtos_pkg::OFFSET_W-1:0]   n_reg;
    logic [dtos_pkg::HOUR_W-1:0]     h_reg;
    logic [dtos_pkg::MINUTE_W-1:0]   mi_reg;
    logic [dtos_pkg::SECOND_W-1:0]   s_reg;
    logic [dtos_pkg::TOD_W-1:0]      tod_reg;
    logic [dtos_pkg::Y400_Q_W-1:0]   q400_reg;
    logic                            neg_reg;

    // Walking calendar position.
    logic [dtos_pkg::DAY_W-1:0]      cd_reg;
    logic [dtos_pkg::MONTH_W-1:0]    cm_reg;
    logic [dtos_pkg::YEAR_W-1:0]     cy_reg;
    logic [dtos_pkg::CYCLE_W-1:0]    c400_reg;
    logic [dtos_pkg::QUOT_W-1:0]     days_reg;
    logic                            oor_reg;

    logic [dtos_pkg::TOD_W-1:0]      r_reg;
    logic [dtos_pkg::HOUR_W-1:0]     hour_reg;
    logic [dtos_pkg::HREM_W-1:0]     hrem_reg;
    logic [dtos_pkg::MINUTE_W-1:0]   min_reg;

    logic                            out_valid_reg;
    logic [dtos_pkg::DAY_W-1:0]      res_day_reg;
    logic [dtos_pkg::MONTH_W-1:0]    res_month_reg;
    logic [dtos_pkg::YEAR_W-1:0]     res_year_reg;
    logic [dtos_pkg::HOUR_W-1:0]     res_hour_reg;
    logic [dtos_pkg::MINUTE_W-1:0]   res_minute_reg;
    logic [dtos_pkg::SECOND_W-1:0]   res_second_reg;
    logic                            res_oor_reg;

    logic                            accept;
    logic                            div_start;
    logic                            div_done;
    logic [dtos_pkg::QUOT_W-1:0]     div_quot;
    logic [dtos_pkg::TOD_W-1:0]      div_rem;
    logic                            out_load;

    // Datapath terms.
    logic [dtos_pkg::YEAR_W+dtos_pkg::YEAR_W-1:0] year_prod;
    logic [dtos_pkg::TOD_W-1:0]      tod_calc;
    logic [dtos_pkg::CYCLE_W-1:0]    c400_calc;
    logic [dtos_pkg::DAY_W-1:0]      ml_start;
    logic [dtos_pkg::DIVIDEND_W-1:0] dividend;
    logic                            neg_calc;
    logic                            leap;
    logic [dtos_pkg::DAY_W-1:0]      ml;
    logic [dtos_pkg::DAY_W-1:0]      left;
    logic                            walk_fits;
    logic                            walk_oor;
    logic [2*dtos_pkg::TOD_W-1:0]    hour_prod;
    logic [2*dtos_pkg::HREM_W:0]     min_prod;
    logic [dtos_pkg::SECOND_W-1:0]   sec_calc;

    dtos_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        year_prod = (2*dtos_pkg::YEAR_W)'(cy_reg) * (2*dtos_pkg::YEAR_W)'(dtos_pkg::Y400_RECIP);
        tod_calc  = dtos_pkg::TOD_W'(h_reg) * dtos_pkg::TOD_W'(3600)
                  + dtos_pkg::TOD_W'(mi_reg) * dtos_pkg::TOD_W'(60)
                  + dtos_pkg::TOD_W'(s_reg);
        c400_calc = dtos_pkg::CYCLE_W'(cy_reg - dtos_pkg::YEAR_W'(q400_reg)
                  * dtos_pkg::YEAR_W'(dtos_pkg::CYCLE_YEARS));
        ml_start  = dtos_pkg::month_len(cm_reg, dtos_pkg::is_leap(c400_calc));
        neg_calc  = (op_reg == dtos_pkg::OP_BACKWARD)
                 && (dtos_pkg::DIVIDEND_W'(n_reg) > dtos_pkg::DIVIDEND_W'(tod_reg));
        if (op_reg == dtos_pkg::OP_FORWARD)
        begin
            dividend = dtos_pkg::DIVIDEND_W'(n_reg) + dtos_pkg::DIVIDEND_W'(tod_reg);
        end
        else if (neg_calc)
        begin
            dividend = dtos_pkg::DIVIDEND_W'(n_reg) - dtos_pkg::DIVIDEND_W'(tod_reg);
        end
        else
        begin
            dividend = dtos_pkg::DIVIDEND_W'(tod_reg) - dtos_pkg::DIVIDEND_W'(n_reg);
        end

        leap = dtos_pkg::is_leap(c400_reg);
        ml   = dtos_pkg::month_len(cm_reg, leap);
        left = ml - cd_reg;
        if (neg_reg)
        begin
            walk_fits = days_reg < dtos_pkg::QUOT_W'(cd_reg);
            walk_oor  = !walk_fits && (cm_reg == dtos_pkg::MONTH_W'(dtos_pkg::MONTH_JAN))
                     && (cy_reg == '0);
        end
        else
        begin
            walk_fits = days_reg <= dtos_pkg::QUOT_W'(left);
            walk_oor  = !walk_fits && (cm_reg == dtos_pkg::MONTH_W'(dtos_pkg::MONTH_DEC))
                     && (cy_reg == dtos_pkg::YEAR_W'(dtos_pkg::YEAR_MAX));
        end

        hour_prod = (2*dtos_pkg::TOD_W)'(r_reg) * (2*dtos_pkg::TOD_W)'(dtos_pkg::HOUR_RECIP);
        min_prod  = (2*dtos_pkg::HREM_W+1)'(hrem_reg)
                  * (2*dtos_pkg::HREM_W+1)'(dtos_pkg::MIN_RECIP);
        sec_calc  = dtos_pkg::SECOND_W'(hrem_reg - dtos_pkg::HREM_W'(min_reg)
                  * dtos_pkg::HREM_W'(60));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtos_pkg::ST_IDLE:  if (item.valid) state_next = dtos_pkg::ST_PREP;
            dtos_pkg::ST_PREP:  state_next = dtos_pkg::ST_CLAMP;
            dtos_pkg::ST_CLAMP: state_next = dtos_pkg::ST_DIV;
            dtos_pkg::ST_DIV:   if (div_done) state_next = dtos_pkg::ST_ADJ;
            dtos_pkg::ST_ADJ:   state_next = dtos_pkg::ST_WALK;
            dtos_pkg::ST_WALK:  if (walk_fits || walk_oor) state_next = dtos_pkg::ST_HOUR;
            dtos_pkg::ST_HOUR:  state_next = dtos_pkg::ST_HREM;
            dtos_pkg::ST_HREM:  state_next = dtos_pkg::ST_MIN;
            dtos_pkg::ST_MIN:   state_next = dtos_pkg::ST_DONE;
            dtos_pkg::ST_DONE:  if (!out_valid_reg || result.ready) state_next = dtos_pkg::ST_IDLE;
            default:            state_next = dtos_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        item.ready = (state_reg == dtos_pkg::ST_IDLE);
        div_start  = (state_reg == dtos_pkg::ST_CLAMP);
        out_load   = (state_reg == dtos_pkg::ST_DONE) && (!out_valid_reg || result.ready);
    end

    assign accept = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtos_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            dtos_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    raw_day_reg    <= item.day;
                    raw_month_reg  <= item.month;
                    raw_year_reg   <= item.year;
                    raw_hour_reg   <= item.hour;
                    raw_minute_reg <= item.minute;
                    raw_second_reg <= item.second;
                    op_reg         <= item.opcode;
                    n_reg          <= item.offset_seconds;
                    cy_reg         <= item.year;
                    oor_reg        <= 1'b0;
                    if (item.month == '0)
                    begin
                        cm_reg <= dtos_pkg::MONTH_W'(dtos_pkg::MONTH_JAN);
                    end
                    else if (item.month > dtos_pkg::MONTH_W'(dtos_pkg::MONTH_DEC))
                    begin
                        cm_reg <= dtos_pkg::MONTH_W'(dtos_pkg::MONTH_DEC);
                    end
                    else
                    begin
                        cm_reg <= item.month;
                    end
                    h_reg  <= (item.hour > 5'd23) ? 5'd23 : item.hour;
                    mi_reg <= (item.minute > 6'd59) ? 6'd59 : item.minute;
                    s_reg  <= (item.second > 6'd59) ? 6'd59 : item.second;
                end
            end
            dtos_pkg::ST_PREP:
            begin
                q400_reg <= year_prod[dtos_pkg::Y400_SHIFT +: dtos_pkg::Y400_Q_W];
                tod_reg  <= tod_calc;
            end
            dtos_pkg::ST_CLAMP:
            begin
                c400_reg <= c400_calc;
                neg_reg  <= neg_calc;
                if (raw_day_reg == '0)
                begin
                    cd_reg <= 5'd1;
                end
                else if (raw_day_reg > ml_start)
                begin
                    cd_reg <= ml_start;
                end
                else
                begin
                    cd_reg <= raw_day_reg;
                end
            end
            dtos_pkg::ST_DIV:
            begin
            end
            dtos_pkg::ST_ADJ:
            begin
                // Floor division: a negative time with a nonzero remainder borrows a day.
                if (neg_reg && (div_rem != '0))
                begin
                    days_reg <= div_quot + 1'b1;
                    r_reg    <= dtos_pkg::TOD_W'(dtos_pkg::SECS_PER_DAY) - div_rem;
                end
                else
                begin
                    days_reg <= div_quot;
                    r_reg    <= div_rem;
                end
            end
            dtos_pkg::ST_WALK:
            begin
                if (walk_fits)
                begin
                    cd_reg <= neg_reg ? cd_reg - days_reg[dtos_pkg::DAY_W-1:0]
                                      : cd_reg + days_reg[dtos_pkg::DAY_W-1:0];
                end
                else if (walk_oor)
                begin
                    oor_reg <= 1'b1;
                end
                else if (!neg_reg)
                begin
                    days_reg <= days_reg - dtos_pkg::QUOT_W'(left) - 1'b1;
                    cd_reg   <= 5'd1;
                    if (cm_reg == dtos_pkg::MONTH_W'(dtos_pkg::MONTH_DEC))
                    begin
                        cm_reg   <= dtos_pkg::MONTH_W'(dtos_pkg::MONTH_JAN);
                        cy_reg   <= cy_reg + 1'b1;
                        c400_reg <= (c400_reg == dtos_pkg::CYCLE_W'(dtos_pkg::CYCLE_YEARS - 1))
                                  ? '0 : c400_reg + 1'b1;
                    end
                    else
                    begin
                        cm_reg <= cm_reg + 1'b1;
                    end
                end
                else
                begin
                    // Stepping back past day one lands on the last day of the prior month.
                    days_reg <= days_reg - dtos_pkg::QUOT_W'(cd_reg);
                    if (cm_reg == dtos_pkg::MONTH_W'(dtos_pkg::MONTH_JAN))
                    begin
                        cm_reg   <= dtos_pkg::MONTH_W'(dtos_pkg::MONTH_DEC);
                        cy_reg   <= cy_reg - 1'b1;
                        c400_reg <= (c400_reg == '0)
                                  ? dtos_pkg::CYCLE_W'(dtos_pkg::CYCLE_YEARS - 1)
                                  : c400_reg - 1'b1;
                        cd_reg   <= 5'd31;
                    end
                    else
                    begin
                        cm_reg <= cm_reg - 1'b1;
                        cd_reg <= dtos_pkg::month_len(cm_reg - 1'b1, leap);
                    end
                end
            end
            dtos_pkg::ST_HOUR:
            begin
                hour_reg <= hour_prod[dtos_pkg::HOUR_SHIFT +: dtos_pkg::HOUR_W];
            end
            dtos_pkg::ST_HREM:
            begin
                hrem_reg <= dtos_pkg::HREM_W'(r_reg - dtos_pkg::TOD_W'(hour_reg)
                          * dtos_pkg::TOD_W'(3600));
            end
            dtos_pkg::ST_MIN:
            begin
                min_reg <= min_prod[dtos_pkg::MIN_SHIFT +: dtos_pkg::MINUTE_W];
            end
            dtos_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    res_oor_reg <= oor_reg;
                    if (oor_reg)
                    begin
                        res_day_reg    <= raw_day_reg;
                        res_month_reg  <= raw_month_reg;
                        res_year_reg   <= raw_year_reg;
                        res_hour_reg   <= raw_hour_reg;
                        res_minute_reg <= raw_minute_reg;
                        res_second_reg <= raw_second_reg;
                    end
                    else
                    begin
                        res_day_reg    <= cd_reg;
                        res_month_reg  <= cm_reg;
                        res_year_reg   <= cy_reg;
                        res_hour_reg   <= hour_reg;
                        res_minute_reg <= min_reg;
                        res_second_reg <= sec_calc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.valid        = out_valid_reg;
    assign result.res_day      = res_day_reg;
    assign result.res_month    = res_month_reg;
    assign result.res_year     = res_year_reg;
    assign result.res_hour     = res_hour_reg;
    assign result.res_minute   = res_minute_reg;
    assign result.res_second   = res_second_reg;
    assign result.out_of_range = res_oor_reg;

endmodule

// ===== hw/rtl/dtos_checker.sv =====
// ----------------------------------------------------------------------------
// Date and time offset port checker
// Watches the top-level channels for ordering and result sanity.
// ----------------------------------------------------------------------------
`include "datetime_offset_seconds_core_macros.svh"

module dtos_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [dtos_pkg::DAY_W-1:0]        res_day,
    input logic [dtos_pkg::MONTH_W-1:0]      res_month,
    input logic [dtos_pkg::YEAR_W-1:0]       res_year,
    input logic [dtos_pkg::HOUR_W-1:0]       res_hour,
    input logic [dtos_pkg::MINUTE_W-1:0]     res_minute,
    input logic [dtos_pkg::SECOND_W-1:0]     res_second,
    input logic                              out_of_range
);

    // A stalled result transaction keeps its payload.
    `DTOS_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(res_day) && $stable(res_month) && $stable(res_year) && $stable(res_hour) && $stable(res_minute) && $stable(res_second) && $stable(out_of_range))

    // A computed moment has its month, hour, minute and second in range and a nonzero day.
    `DTOS_ASSERT_IMPL(a_result_range, clk, rst_n, result_valid && !out_of_range, res_month >= 4'd1 && res_month <= 4'd12 && res_day >= 5'd1 && res_hour <= 5'd23 && res_minute <= 6'd59 && res_second <= 6'd59)

    // The block works on one transaction at a time.
    `DTOS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && item_ready, !item_ready)

    // No result can appear right after an input transaction.
    `DTOS_ASSERT_NEXT(a_no_instant_result, clk, rst_n, item_valid && item_ready, !$rose(result_valid))

endmodule

bind datetime_offset_seconds_core dtos_checker u_dtos_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .res_day      (result.res_day),
    .res_month    (result.res_month),
    .res_year     (result.res_year),
    .res_hour     (result.res_hour),
    .res_minute   (result.res_minute),
    .res_second   (result.res_second),
    .out_of_range (result.out_of_range)
);
